### rtl/swerm_pkg.sv
// Shared constants, state codes and controller/datapath link types for the
// sliding window event rate meter. No dependencies.
package swerm_pkg;

   localparam int RING_DEPTH  = 256;   // stamps kept in the ring
   localparam int FRAC_BITS   = 8;     // fraction bits of the rate
   localparam int MS_PER_SEC  = 1000;

   localparam int TIME_W      = 32;
   localparam int WIN_W       = 16;
   localparam int RATE_W      = 26;
   localparam int EVT_W       = 9;
   localparam int ADDR_W      = $clog2(RING_DEPTH);
   localparam int COUNT_W     = $clog2(RING_DEPTH + 1);
   // numerator (count-1)*1000 << FRAC_BITS at its largest
   localparam int NUM_W       = $clog2((((RING_DEPTH - 1) * MS_PER_SEC) << FRAC_BITS) + 1);
   localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

   localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(500);
   localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};
   localparam logic [EVT_W-1:0]  EVT_MAX      = {EVT_W{1'b1}};

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic start;      // take the new stamp, set up the walk
      logic walk;       // one step of the ring walk
      logic eval;       // decide update, load divider
      logic div_step;   // one quotient bit
      logic load_out;   // move result to the output register
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic do_div;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

### rtl/swerm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module swerm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/swerm_ctrl.sv
// Sequencer for the rate meter: walk, evaluate, divide, hand off.
// Depends on swerm_pkg.
module swerm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swerm_pkg::status_type status,
   output swerm_pkg::cmd_type    cmd
);

   swerm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         swerm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = swerm_pkg::ST_WALK;
            end
         end
         swerm_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = swerm_pkg::ST_EVAL;
            end
         end
         swerm_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.do_div ? swerm_pkg::ST_DIV : swerm_pkg::ST_DONE;
         end
         swerm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = swerm_pkg::ST_DONE;
            end
         end
         swerm_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = swerm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swerm_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == swerm_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swerm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/swerm_dp.sv
// Datapath of the rate meter: stamp ring, walk counters, serial divider,
// window register and output register. Depends on swerm_pkg, swerm_ram.
module swerm_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  swerm_pkg::cmd_type                  cmd,
   output swerm_pkg::status_type               status,
   input  logic [swerm_pkg::TIME_W-1:0]        req_event_time_ms,
   input  logic                                csr_we,
   input  logic [swerm_pkg::WIN_W-1:0]         csr_window_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [swerm_pkg::RATE_W-1:0]        rsp_rate_q8,
   output logic [swerm_pkg::EVT_W-1:0]         rsp_events_in_window,
   output logic                                rsp_rate_updated
);

   localparam logic [swerm_pkg::ADDR_W-1:0]  LAST_SLOT = swerm_pkg::ADDR_W'(swerm_pkg::RING_DEPTH - 1);
   localparam logic [swerm_pkg::COUNT_W-1:0] DEPTH_C   = swerm_pkg::COUNT_W'(swerm_pkg::RING_DEPTH);

   // control state
   logic [swerm_pkg::WIN_W-1:0]     window_ff, window_in;
   logic [swerm_pkg::ADDR_W-1:0]    slot_ff, slot_in;
   logic [swerm_pkg::COUNT_W-1:0]   fill_ff, fill_in;
   logic [swerm_pkg::RATE_W-1:0]    last_rate_ff, last_rate_in;
   logic [swerm_pkg::COUNT_W-1:0]   left_ff, left_in;
   logic                            pend_ff, pend_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   // payload
   logic [swerm_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [swerm_pkg::TIME_W-1:0]    cutoff_ff, cutoff_in;
   logic [swerm_pkg::TIME_W-1:0]    oldest_ff, oldest_in;
   logic [swerm_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [swerm_pkg::ADDR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic                            upd_ff, upd_in;
   logic [swerm_pkg::TIME_W-1:0]    span_ff, span_in;
   logic [swerm_pkg::TIME_W-1:0]    rem_ff, rem_in;
   logic [swerm_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [swerm_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [swerm_pkg::RATE_W-1:0]    out_rate_ff, out_rate_in;
   logic [swerm_pkg::EVT_W-1:0]     out_evt_ff, out_evt_in;
   logic                            out_upd_ff, out_upd_in;

   logic [swerm_pkg::TIME_W-1:0]    rd_data;
   logic                            hit_fail;
   logic                            issue;
   logic [swerm_pkg::COUNT_W-1:0]   cnt_m1;
   logic [swerm_pkg::NUM_W-1:0]     num_start;
   logic [swerm_pkg::TIME_W:0]      rem_sh;
   logic [swerm_pkg::TIME_W:0]      diff;
   logic [swerm_pkg::RATE_W-1:0]    quo_sat;
   logic [swerm_pkg::RATE_W-1:0]    new_rate;

   swerm_ram #(
      .WIDTH (swerm_pkg::TIME_W),
      .DEPTH (swerm_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.start),
      .wr_addr (slot_ff),
      .wr_data (req_event_time_ms),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // walk: a read is in flight when pend_ff; stop issuing on the first stale stamp
   assign hit_fail = pend_ff && (rd_data < cutoff_ff);
   assign issue    = cmd.walk && (left_ff != '0) && !hit_fail;

   assign cnt_m1    = count_ff - swerm_pkg::COUNT_W'(1);
   assign num_start = (swerm_pkg::NUM_W'(cnt_m1) * swerm_pkg::NUM_W'(swerm_pkg::MS_PER_SEC))
                      << swerm_pkg::FRAC_BITS;

   assign rem_sh = {rem_ff, quo_ff[swerm_pkg::NUM_W-1]};
   assign diff   = rem_sh - {1'b0, span_ff};

   assign quo_sat  = ({{(64 - swerm_pkg::NUM_W){1'b0}}, quo_ff} > 64'(swerm_pkg::RATE_MAX))
                     ? swerm_pkg::RATE_MAX : swerm_pkg::RATE_W'(quo_ff);
   assign new_rate = upd_ff ? quo_sat : last_rate_ff;

   always_comb begin
      window_in    = window_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      last_rate_in = last_rate_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      now_in       = now_ff;
      cutoff_in    = cutoff_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      upd_in       = upd_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      out_rate_in  = out_rate_ff;
      out_evt_in   = out_evt_ff;
      out_upd_in   = out_upd_ff;

      if (csr_we) begin
         window_in = csr_window_ms;
      end

      if (cmd.start) begin
         now_in    = req_event_time_ms;
         cutoff_in = (req_event_time_ms > swerm_pkg::TIME_W'(window_ff))
                     ? req_event_time_ms - swerm_pkg::TIME_W'(window_ff) : '0;
         oldest_in = req_event_time_ms;
         count_in  = swerm_pkg::COUNT_W'(1);
         slot_in   = (slot_ff == LAST_SLOT) ? '0 : slot_ff + swerm_pkg::ADDR_W'(1);
         rd_ptr_in = (slot_ff == '0) ? LAST_SLOT : slot_ff - swerm_pkg::ADDR_W'(1);
         // older entries available = min(fill, depth - 1)
         left_in   = (fill_ff < DEPTH_C) ? fill_ff : DEPTH_C - swerm_pkg::COUNT_W'(1);
         if (fill_ff < DEPTH_C) begin
            fill_in = fill_ff + swerm_pkg::COUNT_W'(1);
         end
         pend_in   = 1'b0;
      end

      if (cmd.walk) begin
         pend_in = issue;
         if (issue) begin
            left_in   = left_ff - swerm_pkg::COUNT_W'(1);
            rd_ptr_in = (rd_ptr_ff == '0) ? LAST_SLOT : rd_ptr_ff - swerm_pkg::ADDR_W'(1);
         end
         if (hit_fail) begin
            left_in = '0;
         end else if (pend_ff) begin
            count_in  = count_ff + swerm_pkg::COUNT_W'(1);
            oldest_in = rd_data;
         end
      end

      if (cmd.eval) begin
         upd_in     = status.do_div;
         span_in    = now_ff - oldest_ff;
         rem_in     = '0;
         quo_in     = num_start;
         div_cnt_in = swerm_pkg::DIV_CNT_W'(swerm_pkg::NUM_W);
      end

      // restoring division, numerator shifts out as quotient shifts in
      if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff - swerm_pkg::DIV_CNT_W'(1);
         if (!diff[swerm_pkg::TIME_W]) begin
            rem_in = diff[swerm_pkg::TIME_W-1:0];
            quo_in = {quo_ff[swerm_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[swerm_pkg::TIME_W-1:0];
            quo_in = {quo_ff[swerm_pkg::NUM_W-2:0], 1'b0};
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         last_rate_in = new_rate;
         out_rate_in  = new_rate;
         out_upd_in   = upd_ff;
         out_evt_in   = (count_ff > swerm_pkg::COUNT_W'(swerm_pkg::EVT_MAX))
                        ? swerm_pkg::EVT_MAX : swerm_pkg::EVT_W'(count_ff);
      end
   end

   always_comb begin
      status.walk_done = (left_ff == '0) && !pend_ff;
      status.do_div    = (count_ff >= swerm_pkg::COUNT_W'(2)) && (oldest_ff < now_ff);
      status.div_last  = (div_cnt_ff == swerm_pkg::DIV_CNT_W'(1));
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= swerm_pkg::WINDOW_RESET;
         slot_ff      <= '0;
         fill_ff      <= '0;
         last_rate_ff <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         last_rate_ff <= last_rate_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      cutoff_ff   <= cutoff_in;
      oldest_ff   <= oldest_in;
      count_ff    <= count_in;
      rd_ptr_ff   <= rd_ptr_in;
      upd_ff      <= upd_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      out_rate_ff <= out_rate_in;
      out_evt_ff  <= out_evt_in;
      out_upd_ff  <= out_upd_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_rate_q8          = out_rate_ff;
   assign rsp_events_in_window = out_evt_ff;
   assign rsp_rate_updated     = out_upd_ff;

endmodule

### rtl/sliding_window_event_rate_meter.sv
// Top level of the sliding window event rate meter.
// Depends on swerm_pkg, swerm_ctrl, swerm_dp (and swerm_ram below it).
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------------
//   req      | in        | req_valid/req_ready   | req_event_time_ms[31:0]
//   rsp      | out       | rsp_valid/rsp_ready   | rsp_rate_q8[25:0], rsp_events_in_window[8:0],
//            |           |                       | rsp_rate_updated
//   csr      | in        | csr_valid/csr_ready   | csr_window_ms[15:0]
//
// Steps: one req beat is accepted, then walked (W = older stamps read, at
// most 255, one ring read per cycle with the read latency overlapped), then
// evaluated, then divided (one quotient bit per cycle, skipped when the rate
// is kept), then loaded into the output register. The ring walk over the
// stamp RAM read port and the bit-serial divider set the time a beat takes.
// Reset is synchronous; the ring needs no clearing pass, only entries already
// written are read. Window resets to 500 ms.
// req_ready is high only while idle. The result sits in an output register, so
// the next req beat is taken while a rsp beat still waits; a stalled rsp only
// holds the next result in the done state.
module sliding_window_event_rate_meter (
   input  logic                               clock,
   input  logic                               reset,
   // event input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [swerm_pkg::TIME_W-1:0]       req_event_time_ms,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [swerm_pkg::RATE_W-1:0]       rsp_rate_q8,
   output logic [swerm_pkg::EVT_W-1:0]        rsp_events_in_window,
   output logic                               rsp_rate_updated,
   // window register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swerm_pkg::WIN_W-1:0]        csr_window_ms
);

   swerm_pkg::cmd_type    cmd;
   swerm_pkg::status_type status;

   // the user must send window writes only while idle; the block does not enforce it. Writes are always taken.
   assign csr_ready = 1'b1;

   swerm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swerm_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_event_time_ms    (req_event_time_ms),
      .csr_we               (csr_valid & csr_ready),
      .csr_window_ms        (csr_window_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_rate_q8          (rsp_rate_q8),
      .rsp_events_in_window (rsp_events_in_window),
      .rsp_rate_updated     (rsp_rate_updated)
   );

endmodule

### verif/sliding_window_event_rate_meter_tb.sv
// Self-checking testbench for sliding_window_event_rate_meter: event beats in, rate beats out,
// each checked against an in-bench model of the stamp ring, window walk and rate divide.
// Depends on swerm_pkg and the RTL top level only.
module sliding_window_event_rate_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 8;
   localparam int TAIL_CYCLES  = 300;     // a bit more than the longest walk plus divide
   localparam int DRAIN_LIMIT  = 20000;   // cycles to wait for outstanding rate beats
   localparam int LOG_LIMIT    = 40;      // mismatch lines printed before going quiet

   // one rate beat, as the block should present it
   typedef struct packed {
      logic [swerm_pkg::RATE_W-1:0] rate_q8;
      logic [swerm_pkg::EVT_W-1:0]  evt_count;
      logic                         updated;
   } rate_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [swerm_pkg::TIME_W-1:0]   req_event_time_ms = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [swerm_pkg::RATE_W-1:0]   rsp_rate_q8;
   logic [swerm_pkg::EVT_W-1:0]    rsp_events_in_window;
   logic                           rsp_rate_updated;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [swerm_pkg::WIN_W-1:0]    csr_window_ms = '0;

   // Rate model state: a copy of the stamp ring and the kept rate.
   logic [swerm_pkg::TIME_W-1:0]   stamp_hist [swerm_pkg::RING_DEPTH];
   int unsigned                    hist_wr = 0;
   int unsigned                    hist_fill = 0;
   logic [swerm_pkg::RATE_W-1:0]   held_rate = '0;
   logic [swerm_pkg::WIN_W-1:0]    window_model = swerm_pkg::WINDOW_RESET;

   rate_result_type                rate_expect_q[$];   // predicted rate beats, oldest first

   int                             mismatch_count = 0;
   int                             events_sent = 0;
   int                             rates_checked = 0;
   int                             rate_updates = 0;
   int unsigned                    peak_count = 0;
   int                             windows_set = 0;
   int                             burst_left = 0;
   int                             rsp_hold_left = 0;  // long receiver hold-off, counted below
   int                             ready_run = 0;
   logic [swerm_pkg::TIME_W-1:0]   stamp_clock = '0;

   sliding_window_event_rate_meter uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_event_time_ms    (req_event_time_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_rate_q8          (rsp_rate_q8),
      .rsp_events_in_window (rsp_events_in_window),
      .rsp_rate_updated     (rsp_rate_updated),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_window_ms        (csr_window_ms)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Rate model. Called once per accepted event beat: stores the stamp,
   // walks back from the newest stamp while stamps are at or past the
   // cutoff, and recomputes the rate when at least two stamps were found
   // and the oldest one found lies strictly before now.
   // ------------------------------------------------------------------
   function automatic rate_result_type predict_rate(input logic [swerm_pkg::TIME_W-1:0] now);
      logic [swerm_pkg::TIME_W-1:0] cutoff;
      logic [swerm_pkg::TIME_W-1:0] oldest;
      logic [63:0]                  quotient;
      int unsigned                  pos;
      int unsigned                  found;
      rate_result_type              res;
      stamp_hist[hist_wr] = now;
      hist_wr = (hist_wr + 1) % swerm_pkg::RING_DEPTH;
      if (hist_fill < swerm_pkg::RING_DEPTH) hist_fill++;
      // cutoff clamps at zero while now is inside the first window
      cutoff = (now > swerm_pkg::TIME_W'(window_model))
               ? now - swerm_pkg::TIME_W'(window_model) : '0;
      oldest = now;
      found  = 0;
      pos    = hist_wr;
      for (int unsigned i = 0; i < hist_fill; i++) begin
         pos = (pos == 0) ? swerm_pkg::RING_DEPTH - 1 : pos - 1;
         if (stamp_hist[pos] < cutoff) break;
         oldest = stamp_hist[pos];
         found++;
      end
      res.updated = 1'b0;
      // an oldest found stamp at or after now makes the span zero or meaningless: keep the rate
      if (found >= 2 && oldest < now) begin
         quotient  = ((64'(found - 1) * swerm_pkg::MS_PER_SEC) << swerm_pkg::FRAC_BITS)
                     / 64'(now - oldest);
         held_rate = (quotient > 64'(swerm_pkg::RATE_MAX))
                     ? swerm_pkg::RATE_MAX : quotient[swerm_pkg::RATE_W-1:0];
         res.updated = 1'b1;
         rate_updates++;
      end
      res.rate_q8   = held_rate;
      res.evt_count = (found > swerm_pkg::EVT_MAX)
                      ? swerm_pkg::EVT_MAX : found[swerm_pkg::EVT_W-1:0];
      if (found > peak_count) peak_count = found;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= LOG_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
      else if (mismatch_count == LOG_LIMIT + 1) $display("ERROR: further mismatches not shown");
   endtask

   // ------------------------------------------------------------------
   // Receiver: ready in random runs with short stalls between them. A
   // test may request a long hold-off through rsp_hold_left.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (ready_run > 0) begin
         ready_run--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         ready_run = $urandom_range(0, 12);
      end else begin
         rsp_ready <= 1'b1;
         ready_run = $urandom_range(0, 60);
      end
   end

   // ------------------------------------------------------------------
   // Result checker: every rsp beat against the oldest prediction.
   // Values read here are the ones present at the edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rate_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rate_expect_q.size() == 0) begin
            report_mismatch($sformatf("rsp beat with nothing expected: rate %0d count %0d upd %0b",
                                      rsp_rate_q8, rsp_events_in_window, rsp_rate_updated));
         end else begin
            want = rate_expect_q.pop_front();
            rates_checked++;
            if (rsp_rate_q8 !== want.rate_q8)
               report_mismatch($sformatf("beat %0d rate_q8 %0d, expected %0d",
                                         rates_checked, rsp_rate_q8, want.rate_q8));
            if (rsp_events_in_window !== want.evt_count)
               report_mismatch($sformatf("beat %0d events_in_window %0d, expected %0d",
                                         rates_checked, rsp_events_in_window, want.evt_count));
            if (rsp_rate_updated !== want.updated)
               report_mismatch($sformatf("beat %0d rate_updated %0b, expected %0b",
                                         rates_checked, rsp_rate_updated, want.updated));
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender: offers one event beat and holds it until taken. Works in
   // bursts; at the end of a burst valid drops for a random gap, mostly
   // short, sometimes long enough to land after the block has gone idle.
   // Valid stays high between back-to-back beats of a burst.
   // ------------------------------------------------------------------
   task automatic send_event(input logic [swerm_pkg::TIME_W-1:0] stamp);
      int gap;
      req_valid         <= 1'b1;
      req_event_time_ms <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rate_expect_q.push_back(predict_rate(stamp));
      events_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 320) : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drops valid and waits until every predicted rate beat has arrived.
   task automatic wait_results_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (rate_expect_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (rate_expect_q.size() != 0) begin
         report_mismatch($sformatf("%0d rate beats never arrived", rate_expect_q.size()));
         rate_expect_q.delete();
      end
   endtask

   // Window register write; only called with the block idle.
   task automatic write_window(input logic [swerm_pkg::WIN_W-1:0] window);
      csr_valid     <= 1'b1;
      csr_window_ms <= window;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      window_model = window;
      windows_set++;
   endtask

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Reset window of 500 ms: lone stamp, repeated stamp (zero span),
   // first real update, then a stamp that goes back in time.
   task automatic test_startup_window();
      send_event(32'd0);
      send_event(32'd0);
      send_event(32'd10);
      send_event(32'd5);
   endtask

   // Zero window: only stamps at or after now count; at now = 0 the cutoff
   // clamps to zero and every stored stamp is counted.
   task automatic test_zero_window();
      wait_results_idle();
      write_window(16'd0);
      send_event(32'd100);
      send_event(32'd100);
      send_event(32'd100);
      send_event(32'd101);
      send_event(32'd0);
   endtask

   // The oldest stamp in the window lies after now: rate must be kept.
   task automatic test_stamp_after_now();
      wait_results_idle();
      write_window(16'd10);
      send_event(32'd200);
      send_event(32'd150);
   endtask

   // Largest window and stamps at the top of the time range.
   task automatic test_time_extremes();
      wait_results_idle();
      write_window(16'hFFFF);
      send_event(32'hFFFF_0000);
      send_event(32'hFFFF_FFFF);
      send_event(32'hFFFF_FFFF);
      send_event(32'd0);
   endtask

   // One ms window: span of one ms, high rate.
   task automatic test_window_one();
      wait_results_idle();
      write_window(16'd1);
      send_event(32'd7);
      send_event(32'd8);
      send_event(32'd8);
   endtask

   // Receiver holds off for a long stretch while events keep coming, so
   // the output register fills and the block stops taking events.
   task automatic test_result_stall();
      wait_results_idle();
      write_window(16'd2000);
      rsp_hold_left = 1500;
      for (int n = 0; n < 10; n++) begin
         stamp_clock = stamp_clock + $urandom_range(1, 20);
         send_event(stamp_clock);
      end
   endtask

   // Mostly non-decreasing stamps with random steps; a few beats jump to
   // a random time or step backward.
   task automatic test_random_traffic(input logic [swerm_pkg::WIN_W-1:0] window,
                                      input int items, input int step_max,
                                      input int noise_pct);
      logic [swerm_pkg::TIME_W-1:0] stamp;
      int                           roll;
      wait_results_idle();
      write_window(window);
      // sometimes start near zero so the clamped cutoff is exercised
      stamp = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 1000);
      for (int n = 0; n < items; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < noise_pct / 2) stamp = $urandom();
         else if (roll < noise_pct) stamp = stamp - $urandom_range(1, 64);
         else stamp = stamp + $urandom_range(0, step_max);
         send_event(stamp);
      end
      stamp_clock = stamp;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_startup_window();
      test_zero_window();
      test_stamp_after_now();
      test_time_extremes();
      test_window_one();

      test_random_traffic(16'd500, 250, 40, 3);     // frame-rate traffic
      test_random_traffic(16'hFFFF, 300, 3, 2);     // dense stamps, ring wraps full
      test_result_stall();
      test_random_traffic(16'd1, 150, 2, 3);
      test_random_traffic(16'd0, 150, 1, 3);
      test_random_traffic(16'd33, 150, 8, 5);
      for (int k = 0; k < 5; k++)
         test_random_traffic(16'($urandom()), 140, $urandom_range(1, 400), 4);

      wait_results_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d events over %0d window settings, %0d checked rate beats.",
               events_sent, windows_set, rates_checked);
      $display("Rate recomputed %0d times; up to %0d stamps counted in one window.",
               rate_updates, peak_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/swerm_pkg.sv
rtl/swerm_ram.sv
rtl/swerm_ctrl.sv
rtl/swerm_dp.sv
rtl/sliding_window_event_rate_meter.sv
verif/sliding_window_event_rate_meter_tb.sv
